@@ rtl/dtpc_pkg.sv @@
// Shared types and constants for the diagonal triple pattern counter.
// No dependencies; imported by the core, dtpc_pos and dtpc_sum.
`default_nettype none

package dtpc_pkg;

  // field widths
  localparam int SYM_W    = 8;
  localparam int GEOM_W   = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 3;

  // prefix sum widths, one per pattern stage
  localparam int SUM1_W = 21;
  localparam int SUM2_W = 39;
  localparam int SUM3_W = 55;

  // default grid limits
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYMBOL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYMBOL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_SYMBOL  = 3'd4;

  // register reset values
  localparam logic [GEOM_W-1:0] GRID_ROWS_RST     = 11'd1;
  localparam logic [GEOM_W-1:0] GRID_COLS_RST     = 11'd1;
  localparam logic [SYM_W-1:0]  FIRST_SYMBOL_RST  = 8'd58;  // ':'
  localparam logic [SYM_W-1:0]  SECOND_SYMBOL_RST = 8'd45;  // '-'
  localparam logic [SYM_W-1:0]  THIRD_SYMBOL_RST  = 8'd41;  // ')'

  // position flags of one cell, handed from the position counter to the datapath
  typedef struct packed {
    logic top;   // a row above exists
    logic lft;   // a column to the left exists
    logic last;  // final cell of the frame
  } cell_info_t;

endpackage

`default_nettype wire

@@ rtl/diagonal_triple_pattern_counter_core.sv @@
// Top level of the diagonal triple pattern counter: configuration registers,
// position counter and prefix sum datapath. Depends on dtpc_pkg, dtpc_pos, dtpc_sum.
//
//   channel  | direction | ports                                   | role
//   ---------+-----------+-----------------------------------------+-------------------
//   in       | input     | in_valid, in_stall, in_symbol           | grid cells, row-major
//   out      | output    | out_valid, out_stall, out_pattern_count | one count per frame
//   cfg      | input     | cfg_wr_en, cfg_index, cfg_data          | register writes
//
// One cell per cycle while in_stall is low; in the cell register a cell reads its
// row-above sums from the line buffers, which are addressed at the accept edge.
// The frame count is loaded into the result register as the last cell leaves the cell register.
// Reset clears control state and positions; line buffers are not cleared.
// in_stall rises only while a final cell waits for the previous result to leave.
`default_nettype none

module diagonal_triple_pattern_counter_core
  import dtpc_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input transaction
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SYM_W-1:0]     in_symbol,
  // result transaction
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [SUM3_W-1:0]    out_pattern_count,
  // configuration writes
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [GEOM_W-1:0] grid_rows_r, grid_cols_r;
  logic [SYM_W-1:0]  first_sym_r, second_sym_r, third_sym_r;
  logic              busy;
  logic              acc;
  cell_info_t        cell_flags;
  logic [CW-1:0]     addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= GRID_ROWS_RST;
      grid_cols_r  <= GRID_COLS_RST;
      first_sym_r  <= FIRST_SYMBOL_RST;
      second_sym_r <= SECOND_SYMBOL_RST;
      third_sym_r  <= THIRD_SYMBOL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_ROWS:     grid_rows_r  <= cfg_data[GEOM_W-1:0];
        REG_GRID_COLS:     grid_cols_r  <= cfg_data[GEOM_W-1:0];
        REG_FIRST_SYMBOL:  first_sym_r  <= cfg_data[SYM_W-1:0];
        REG_SECOND_SYMBOL: second_sym_r <= cfg_data[SYM_W-1:0];
        REG_THIRD_SYMBOL:  third_sym_r  <= cfg_data[SYM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input handshake
  assign in_stall = busy;
  assign acc      = in_valid && !busy;

  dtpc_pos #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_i      (acc),
    .grid_rows_i(grid_rows_r),
    .grid_cols_i(grid_cols_r),
    .cell_o     (cell_flags),
    .addr_o     (addr)
  );

  dtpc_sum #(
    .MAX_COLS(MAX_COLS)
  ) u_sum (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_i       (acc),
    .cell_i      (cell_flags),
    .addr_i      (addr),
    .sym_i       (in_symbol),
    .first_sym_i (first_sym_r),
    .second_sym_i(second_sym_r),
    .third_sym_i (third_sym_r),
    .out_stall_i (out_stall),
    .busy_o      (busy),
    .out_valid_o (out_valid),
    .out_count_o (out_pattern_count)
  );

endmodule

`default_nettype wire

@@ rtl/dtpc_ram.sv @@
// Generic single write port RAM with a registered read port.
// No dependencies; used for the line buffers.
`default_nettype none

module dtpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/dtpc_pos.sv @@
// Row and column position counter with geometry clamping.
// Depends on dtpc_pkg; produces the per-cell flags and line buffer address.
`default_nettype none

module dtpc_pos
  import dtpc_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc_i,
  input  wire logic [GEOM_W-1:0] grid_rows_i,
  input  wire logic [GEOM_W-1:0] grid_cols_i,
  output cell_info_t             cell_o,
  output logic      [CW-1:0]     addr_o
);

  localparam int PW    = (CW > RW) ? CW : RW;
  localparam int CMP_W = (PW + 1 > GEOM_W) ? PW + 1 : GEOM_W;

  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_COLS);
  localparam logic [CMP_W-1:0] MAX_R = CMP_W'(MAX_ROWS);
  localparam logic [CMP_W-1:0] ONE   = CMP_W'(1);

  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CMP_W-1:0] cols_g, rows_g, cols_eff, rows_eff;
  logic [CMP_W-1:0] col_inc, row_inc;
  logic             last_col, last_row;

  // clamp geometry to 1..max
  always_comb begin
    cols_g   = CMP_W'(grid_cols_i);
    rows_g   = CMP_W'(grid_rows_i);
    cols_eff = (cols_g == '0) ? ONE : ((cols_g > MAX_C) ? MAX_C : cols_g);
    rows_eff = (rows_g == '0) ? ONE : ((rows_g > MAX_R) ? MAX_R : rows_g);
  end

  // end of row and end of frame detection
  assign col_inc  = CMP_W'(col_r) + ONE;
  assign row_inc  = CMP_W'(row_r) + ONE;
  assign last_col = !(col_inc < cols_eff);
  assign last_row = !(row_inc < rows_eff);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc_i) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // flags of the cell at the current position
  always_comb begin
    cell_o.top  = (row_r != '0);
    cell_o.lft  = (col_r != '0);
    cell_o.last = last_col && last_row;
  end

  assign addr_o = col_r;

endmodule

`default_nettype wire

@@ rtl/dtpc_sum.sv @@
// Prefix sum datapath: cell register, three line buffers, left and diagonal
// registers, and the result register. Depends on dtpc_pkg and dtpc_ram.
`default_nettype none

module dtpc_sum
  import dtpc_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc_i,
  input  wire cell_info_t        cell_i,
  input  wire logic [CW-1:0]     addr_i,
  input  wire logic [SYM_W-1:0]  sym_i,
  input  wire logic [SYM_W-1:0]  first_sym_i,
  input  wire logic [SYM_W-1:0]  second_sym_i,
  input  wire logic [SYM_W-1:0]  third_sym_i,
  input  wire logic              out_stall_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  output logic      [SUM3_W-1:0] out_count_o
);

  // cell register
  logic             s1_v_r, s1_v_nxt;
  logic [SYM_W-1:0] s1_sym_r;
  cell_info_t       s1_info_r;
  logic [CW-1:0]    s1_addr_r;
  logic             fwd_r;
  logic             s1_adv;

  // running neighbor registers
  logic [SUM1_W-1:0] left1_r, diag1_r;
  logic [SUM2_W-1:0] left2_r, diag2_r;
  logic [SUM3_W-1:0] left3_r, diag3_r;

  // line buffer read data
  logic [SUM1_W-1:0] ram1_q;
  logic [SUM2_W-1:0] ram2_q;
  logic [SUM3_W-1:0] ram3_q;

  // neighbor values and new sums
  logic [SUM1_W-1:0] u1, l1, d1, n1;
  logic [SUM2_W-1:0] u2, l2, d2, n2;
  logic [SUM3_W-1:0] u3, l3, d3, n3;
  logic              m1, m2, m3;

  // result register
  logic              out_v_r;
  logic [SUM3_W-1:0] out_cnt_r;

  // a non-final cell always moves on; the final one needs a free result slot
  assign s1_adv = s1_v_r && (!s1_info_r.last || !out_v_r || !out_stall_i);
  assign busy_o = s1_v_r && !s1_adv;

  assign s1_v_nxt = acc_i ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (acc_i) begin
        // one-column grid: row above is the cell being written right now
        fwd_r <= s1_adv && (s1_addr_r == addr_i);
      end else if (s1_adv) begin
        fwd_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_i) begin
      s1_sym_r  <= sym_i;
      s1_info_r <= cell_i;
      s1_addr_r <= addr_i;
    end
  end

  // line buffers: read at accept, written when the cell completes
  dtpc_ram #(.WIDTH(SUM1_W), .DEPTH(MAX_COLS)) u_ram1 (
    .clk    (clk),
    .wr_en  (s1_adv),
    .wr_addr(s1_addr_r),
    .wr_data(n1),
    .rd_en  (acc_i),
    .rd_addr(addr_i),
    .rd_data(ram1_q)
  );

  dtpc_ram #(.WIDTH(SUM2_W), .DEPTH(MAX_COLS)) u_ram2 (
    .clk    (clk),
    .wr_en  (s1_adv),
    .wr_addr(s1_addr_r),
    .wr_data(n2),
    .rd_en  (acc_i),
    .rd_addr(addr_i),
    .rd_data(ram2_q)
  );

  dtpc_ram #(.WIDTH(SUM3_W), .DEPTH(MAX_COLS)) u_ram3 (
    .clk    (clk),
    .wr_en  (s1_adv),
    .wr_addr(s1_addr_r),
    .wr_data(n3),
    .rd_en  (acc_i),
    .rd_addr(addr_i),
    .rd_data(ram3_q)
  );

  // neighbor selection, zero outside the grid
  always_comb begin
    u1 = '0;
    u2 = '0;
    u3 = '0;
    if (s1_info_r.top) begin
      u1 = fwd_r ? left1_r : ram1_q;
      u2 = fwd_r ? left2_r : ram2_q;
      u3 = fwd_r ? left3_r : ram3_q;
    end
    l1 = s1_info_r.lft ? left1_r : '0;
    l2 = s1_info_r.lft ? left2_r : '0;
    l3 = s1_info_r.lft ? left3_r : '0;
    d1 = (s1_info_r.top && s1_info_r.lft) ? diag1_r : '0;
    d2 = (s1_info_r.top && s1_info_r.lft) ? diag2_r : '0;
    d3 = (s1_info_r.top && s1_info_r.lft) ? diag3_r : '0;
  end

  // symbol matches per stage
  assign m1 = (s1_sym_r == first_sym_i);
  assign m2 = (s1_sym_r == second_sym_i);
  assign m3 = (s1_sym_r == third_sym_i);

  // inclusion-exclusion update, each wraps at its own width
  assign n1 = u1 + l1 - d1 + SUM1_W'(m1);
  assign n2 = u2 + l2 - d2 + (m2 ? SUM2_W'(d1) : '0);
  assign n3 = u3 + l3 - d3 + (m3 ? SUM3_W'(d2) : '0);

  // left and diagonal registers follow the completed cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left1_r <= '0;
      left2_r <= '0;
      left3_r <= '0;
      diag1_r <= '0;
      diag2_r <= '0;
      diag3_r <= '0;
    end else if (s1_adv) begin
      left1_r <= n1;
      left2_r <= n2;
      left3_r <= n3;
      diag1_r <= u1;
      diag2_r <= u2;
      diag3_r <= u3;
    end
  end

  // result register, loaded at the end of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_info_r.last) begin
      out_v_r <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_info_r.last) begin
      out_cnt_r <= n3;
    end
  end

  assign out_valid_o = out_v_r;
  assign out_count_o = out_cnt_r;

  // forwarding only ever applies to a cell held in the cell register
  a_fwd_has_cell: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_v_r)
    else $error("forward flag set with empty cell register");

  // back pressure only from a final cell blocked by a pending result
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    busy_o |-> (s1_info_r.last && out_v_r && out_stall_i))
    else $error("input stalled without a blocked frame result");

  // a completed frame always shows up in the result register
  a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_info_r.last) |=> out_v_r)
    else $error("frame result lost");

endmodule

`default_nettype wire
